@@ rtl/pdh_pkg.sv @@
// Shared constants, types and codes for the particle density histogrammer.
package pdh_pkg;

  localparam int Z_BINS     = 256;
  localparam int XY_BINS    = 64;
  localparam int COUNT_BITS = 32;

  localparam int ZB_W       = $clog2(Z_BINS);
  localparam int XYB_W      = $clog2(XY_BINS);
  localparam int SLAB_DEPTH = 4 * XY_BINS * XY_BINS;
  localparam int SA_W       = $clog2(SLAB_DEPTH);
  localparam int CLR_DEPTH  = (SLAB_DEPTH > Z_BINS) ? SLAB_DEPTH : Z_BINS;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  typedef logic [ZB_W-1:0]       zbin_t;
  typedef logic [XYB_W-1:0]      xybin_t;
  typedef logic [SA_W-1:0]       saddr_t;
  typedef logic [CLR_W-1:0]      clr_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  // Band offsets around the walls, Q16.16 in the 35-bit compare width.
  localparam logic signed [34:0] ONE_Q   = 35'sd65536;
  localparam logic signed [34:0] THREE_Q = 35'sd196608;
  localparam logic signed [34:0] FIVE_Q  = 35'sd327680;

  localparam logic [1:0] SLAB_INNER = 2'd0;
  localparam logic [1:0] SLAB_NEAR  = 2'd1;
  localparam logic [1:0] SLAB_MID   = 2'd2;
  localparam logic [1:0] SLAB_OUTER = 2'd3;

  localparam logic [2:0] TBL_Z         = 3'd0;
  localparam logic [2:0] TBL_SLAB_LAST = 3'd4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_RANGE   = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_INV_Z     = 3'd0,
    REG_INV_XY    = 3'd1,
    REG_LOWER     = 3'd2,
    REG_GAP       = 3'd3,
    REG_FIRST     = 3'd4,
    REG_MOBILE    = 3'd5,
    REG_ENABLE_Z  = 3'd6,
    REG_ENABLE_XY = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_Z = 2'd0,
    MUL_X = 2'd1,
    MUL_Y = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic [31:0] inv_width_z;
    logic [31:0] inv_width_xy;
    logic [31:0] lower_wall;
    logic [30:0] wall_gap;
    logic [15:0] first_counted;
    logic [15:0] mobile_count;
    logic        enable_z;
    logic        enable_xy;
  } cfg_t;

  typedef struct packed {
    logic     clear;
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_read;
    logic counted;
  } dp_stat_t;

endpackage

@@ rtl/pdh_ctrl.sv @@
// Sequencing state machine of the particle density histogrammer.
module pdh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pdh_pkg::dp_stat_t stat,
  output pdh_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MZ,
    S_MX,
    S_MY,
    S_ADDR,
    S_UPD
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (stat.is_read) begin
            state_next = S_ADDR;
          end else if (stat.counted) begin
            state_next = S_MZ;
          end else begin
            state_next = S_UPD;
          end
        end
      end
      S_MZ:   state_next = S_MX;
      S_MX:   state_next = S_MY;
      S_MY:   state_next = S_ADDR;
      S_ADDR: state_next = S_UPD;
      S_UPD:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.clear   = (state == S_CLEAR);
    cmd.accept  = (state == S_IDLE) && start;
    cmd.mul_en  = (state == S_MZ) || (state == S_MX) || (state == S_MY);
    cmd.finish  = (state == S_UPD);
    unique case (state)
      S_MX:    cmd.mul_sel = pdh_pkg::MUL_X;
      S_MY:    cmd.mul_sel = pdh_pkg::MUL_Y;
      default: cmd.mul_sel = pdh_pkg::MUL_Z;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ rtl/pdh_dp.sv @@
// Datapath: input latches, shared bin multiplier, slab compare, counter memories, result registers.
module pdh_dp (
  input  logic              clk,
  input  logic              rst,
  input  pdh_pkg::cfg_t     cfg,
  input  pdh_pkg::dp_cmd_t  cmd,
  output pdh_pkg::dp_stat_t stat,
  input  logic              opcode,
  input  logic [15:0]       particle_index,
  input  logic [31:0]       pos_x,
  input  logic [31:0]       pos_y,
  input  logic [31:0]       pos_z,
  input  logic [2:0]        read_table,
  input  logic [7:0]        read_bin_a,
  input  logic [5:0]        read_bin_b,
  output logic              done,
  output logic [1:0]        status,
  output logic [1:0]        slab,
  output logic [7:0]        bin_z_out,
  output logic [5:0]        bin_x_out,
  output logic [5:0]        bin_y_out,
  output logic [31:0]       read_count
);

  // Latched item.
  logic               op_r;
  logic               counted_r;
  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic signed [31:0] z_r;
  logic [2:0]         tbl_r;
  logic [7:0]         a_r;
  logic [5:0]         b_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= opcode;
      counted_r <= stat.counted;
      x_r       <= pos_x;
      y_r       <= pos_y;
      z_r       <= pos_z;
      tbl_r     <= read_table;
      a_r       <= read_bin_a;
      b_r       <= read_bin_b;
    end
  end

  assign stat.is_read = (opcode == pdh_pkg::OP_READ);
  assign stat.counted = (particle_index >= cfg.first_counted) &&
                        (particle_index < cfg.mobile_count);

  // Clearing pass after reset.
  pdh_pkg::clr_t clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign stat.clear_last = (clr_cnt == pdh_pkg::clr_t'(pdh_pkg::CLR_DEPTH - 1));

  // Band edges are registered from the wall registers; they settle before a slab compare
  // provided configuration only changes while idle, which the block itself does not enforce.
  logic signed [34:0] lo35;
  logic signed [34:0] up35;
  logic signed [34:0] lo1, lo3, lo5, up1, up3, up5;

  assign lo35 = 35'($signed(cfg.lower_wall));
  assign up35 = lo35 + $signed(35'(cfg.wall_gap));

  always_ff @(posedge clk) begin
    lo1 <= lo35 - pdh_pkg::ONE_Q;
    lo3 <= lo35 - pdh_pkg::THREE_Q;
    lo5 <= lo35 - pdh_pkg::FIVE_Q;
    up1 <= up35 + pdh_pkg::ONE_Q;
    up3 <= up35 + pdh_pkg::THREE_Q;
    up5 <= up35 + pdh_pkg::FIVE_Q;
  end

  logic signed [34:0] z35;
  logic [1:0]         slab_calc;

  assign z35 = 35'(z_r);

  always_comb begin
    if (z35 > lo1 && z35 < up1) begin
      slab_calc = pdh_pkg::SLAB_INNER;
    end else if ((z35 > lo3 && z35 < lo1) || (z35 > up1 && z35 < up3)) begin
      slab_calc = pdh_pkg::SLAB_NEAR;
    end else if ((z35 > lo5 && z35 < lo3) || (z35 > up3 && z35 < up5)) begin
      slab_calc = pdh_pkg::SLAB_MID;
    end else begin
      slab_calc = pdh_pkg::SLAB_OUTER;
    end
  end

  // Shared multiplier: one axis per cycle. The upper word of the Q32.32 product is the
  // floored bin, since the arithmetic shift rounds toward minus infinity.
  logic signed [31:0] mul_a;
  logic [31:0]        mul_b;
  logic signed [64:0] prod;
  logic [31:0]        kz, kx, ky;
  logic [1:0]         slab_r;

  always_comb begin
    case (cmd.mul_sel)
      pdh_pkg::MUL_X: begin
        mul_a = x_r;
        mul_b = cfg.inv_width_xy;
      end
      pdh_pkg::MUL_Y: begin
        mul_a = y_r;
        mul_b = cfg.inv_width_xy;
      end
      default: begin
        mul_a = z_r;
        mul_b = cfg.inv_width_z;
      end
    endcase
  end

  assign prod = mul_a * $signed({1'b0, mul_b});

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        pdh_pkg::MUL_X: kx <= prod[63:32];
        pdh_pkg::MUL_Y: ky <= prod[63:32];
        default: begin
          kz     <= prod[63:32];
          slab_r <= slab_calc;
        end
      endcase
    end
  end

  logic z_in, x_in, y_in;

  assign z_in = !kz[31] && (kz[30:0] < 31'(pdh_pkg::Z_BINS));
  assign x_in = !kx[31] && (kx[30:0] < 31'(pdh_pkg::XY_BINS));
  assign y_in = !ky[31] && (ky[30:0] < 31'(pdh_pkg::XY_BINS));

  logic is_sample;
  logic z_hit, xy_hit, rd_ok;

  assign is_sample = (op_r == pdh_pkg::OP_SAMPLE) && counted_r;
  assign z_hit     = is_sample && cfg.enable_z && z_in;
  assign xy_hit    = is_sample && cfg.enable_xy && x_in && y_in;
  assign rd_ok     = (tbl_r == pdh_pkg::TBL_Z) ? (32'(a_r) < pdh_pkg::Z_BINS) :
                     ((tbl_r <= pdh_pkg::TBL_SLAB_LAST) &&
                      (32'(a_r) < pdh_pkg::XY_BINS) && (32'(b_r) < pdh_pkg::XY_BINS));

  // Counter memories. Addresses stay put from the read cycle to the write-back cycle.
  pdh_pkg::zbin_t  z_addr;
  pdh_pkg::saddr_t s_addr;
  pdh_pkg::count_t z_q, s_q, z_wdata, s_wdata;
  logic            z_we, s_we;

  pdh_pkg::count_t z_mem [pdh_pkg::Z_BINS];
  pdh_pkg::count_t s_mem [pdh_pkg::SLAB_DEPTH];

  always_comb begin
    if (cmd.clear) begin
      z_addr = pdh_pkg::zbin_t'(clr_cnt);
      s_addr = pdh_pkg::saddr_t'(clr_cnt);
    end else if (op_r == pdh_pkg::OP_READ) begin
      z_addr = pdh_pkg::zbin_t'(a_r);
      s_addr = {2'(tbl_r - 3'd1), pdh_pkg::xybin_t'(a_r), pdh_pkg::xybin_t'(b_r)};
    end else begin
      z_addr = pdh_pkg::zbin_t'(kz);
      s_addr = {slab_r, pdh_pkg::xybin_t'(kx), pdh_pkg::xybin_t'(ky)};
    end
  end

  assign z_we    = cmd.clear || (cmd.finish && z_hit);
  assign s_we    = cmd.clear || (cmd.finish && xy_hit);
  assign z_wdata = cmd.clear ? '0 : ((z_q == pdh_pkg::COUNT_MAX) ? z_q : z_q + 1'b1);
  assign s_wdata = cmd.clear ? '0 : ((s_q == pdh_pkg::COUNT_MAX) ? s_q : s_q + 1'b1);

  always_ff @(posedge clk) begin
    if (z_we) z_mem[z_addr] <= z_wdata;
    z_q <= z_mem[z_addr];
  end

  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_addr] <= s_wdata;
    s_q <= s_mem[s_addr];
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  logic [1:0]  status_next;
  logic [1:0]  slab_next;
  logic [7:0]  bin_z_next;
  logic [5:0]  bin_x_next;
  logic [5:0]  bin_y_next;
  logic [31:0] read_count_next;

  always_comb begin
    status_next     = pdh_pkg::ST_COUNTED;
    slab_next       = '0;
    bin_z_next      = '0;
    bin_x_next      = '0;
    bin_y_next      = '0;
    read_count_next = '0;
    if (op_r == pdh_pkg::OP_READ) begin
      status_next = rd_ok ? pdh_pkg::ST_READ : pdh_pkg::ST_RANGE;
      if (rd_ok) begin
        read_count_next = (tbl_r == pdh_pkg::TBL_Z) ? 32'(z_q) : 32'(s_q);
      end
    end else if (!counted_r) begin
      status_next = pdh_pkg::ST_SKIPPED;
    end else begin
      if ((cfg.enable_z && !z_in) || (cfg.enable_xy && !(x_in && y_in))) begin
        status_next = pdh_pkg::ST_RANGE;
      end
      if (cfg.enable_z && z_in) bin_z_next = kz[7:0];
      if (cfg.enable_xy) begin
        slab_next = slab_r;
        if (x_in) bin_x_next = kx[5:0];
        if (y_in) bin_y_next = ky[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status     <= status_next;
      slab       <= slab_next;
      bin_z_out  <= bin_z_next;
      bin_x_out  <= bin_x_next;
      bin_y_out  <= bin_y_next;
      read_count <= read_count_next;
    end
  end

endmodule

@@ rtl/particle_density_histogrammer_unit.sv @@
// Top level of the particle density histogrammer: configuration registers and block wiring.
//
// Usage: drive an item on the input ports and raise start; the item transfers at a rising
// edge where start is high and busy is low. Opcode 0 bins a particle sample into the z
// histogram and/or the xy table of the slab picked from z against the walls; opcode 1
// reads one counter. Each item gives exactly one result, shown on the result ports for a
// single cycle while done is high; the receiver cannot stall, so the result must be taken
// in that cycle.
// Steps from the transfer to the result: a counted sample makes three passes through the one
// shared bin multiplier, a counter memory read, then the saturating write-back; a read makes
// only the counter memory read, and a sample skipped by its index goes straight to the
// result. Items are handled one at a time; busy drops in the cycle done is high, so a
// new item can transfer then.
// Configuration: write cfg_data to register cfg_index while cfg_write is high, only when
// the block is idle. Registers: 0 z reciprocal, 1 xy reciprocal, 2 lower wall, 3 wall gap,
// 4 first counted index, 5 mobile count, 6 z enable, 7 xy enable.
// Reset (rst, synchronous) restores the register defaults and starts a clearing pass that
// zeroes every counter, one address per cycle; busy stays high throughout, while
// configuration writes are still taken.
module particle_density_histogrammer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        opcode,
  input  logic [15:0] particle_index,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [2:0]  read_table,
  input  logic [7:0]  read_bin_a,
  input  logic [5:0]  read_bin_b,
  output logic        done,
  output logic [1:0]  status,
  output logic [1:0]  slab,
  output logic [7:0]  bin_z_out,
  output logic [5:0]  bin_x_out,
  output logic [5:0]  bin_y_out,
  output logic [31:0] read_count
);

  pdh_pkg::cfg_t     cfg;
  pdh_pkg::dp_cmd_t  cmd;
  pdh_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_width_z   <= 32'd65536;
      cfg.inv_width_xy  <= 32'd65536;
      cfg.lower_wall    <= '0;
      cfg.wall_gap      <= '0;
      cfg.first_counted <= '0;
      cfg.mobile_count  <= 16'd65535;
      cfg.enable_z      <= 1'b0;
      cfg.enable_xy     <= 1'b0;
    end else if (cfg_write) begin
      unique case (pdh_pkg::reg_idx_t'(cfg_index))
        pdh_pkg::REG_INV_Z:     cfg.inv_width_z   <= cfg_data;
        pdh_pkg::REG_INV_XY:    cfg.inv_width_xy  <= cfg_data;
        pdh_pkg::REG_LOWER:     cfg.lower_wall    <= cfg_data;
        pdh_pkg::REG_GAP:       cfg.wall_gap      <= cfg_data[30:0];
        pdh_pkg::REG_FIRST:     cfg.first_counted <= cfg_data[15:0];
        pdh_pkg::REG_MOBILE:    cfg.mobile_count  <= cfg_data[15:0];
        pdh_pkg::REG_ENABLE_Z:  cfg.enable_z      <= cfg_data[0];
        pdh_pkg::REG_ENABLE_XY: cfg.enable_xy     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pdh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pdh_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .opcode         (opcode),
    .particle_index (particle_index),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .read_table     (read_table),
    .read_bin_a     (read_bin_a),
    .read_bin_b     (read_bin_b),
    .done           (done),
    .status         (status),
    .slab           (slab),
    .bin_z_out      (bin_z_out),
    .bin_x_out      (bin_x_out),
    .bin_y_out      (bin_y_out),
    .read_count     (read_count)
  );

  // A result only ever follows a cycle in which the block was working.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // A transfer always takes the block out of idle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item transfer did not start work");

  // Skipped samples and reads carry no slab or bin information.
  assert property (@(posedge clk) disable iff (rst)
      (done && (status == pdh_pkg::ST_SKIPPED || status == pdh_pkg::ST_READ)) |->
      (slab == 2'd0 && bin_z_out == 8'd0 && bin_x_out == 6'd0 && bin_y_out == 6'd0))
    else $error("bin fields set on a skipped sample or a read");

endmodule

@@ sim/tb_particle_density_histogrammer_unit.sv @@
// Self-checking testbench for the particle density histogrammer unit.
`timescale 1ns / 1ps

module tb_particle_density_histogrammer_unit;
  import pdh_pkg::*;

  localparam int     RANDOM_ITEMS   = 1530;
  localparam int     PHASES         = 8;
  localparam int     WATCHDOG_LIMIT = 60000;
  localparam int     DRAIN_CYCLES   = 12;
  localparam longint Q_ONE          = 64'sd65536;

  typedef struct {
    logic        opcode;
    logic [15:0] particle_index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [2:0]  read_table;
    logic [7:0]  read_bin_a;
    logic [5:0]  read_bin_b;
  } hist_item_t;

  typedef struct {
    status_t     status;
    logic [1:0]  slab;
    logic [7:0]  bin_z;
    logic [5:0]  bin_x;
    logic [5:0]  bin_y;
    logic [31:0] count;
  } hist_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        opcode;
  logic [15:0] particle_index;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [2:0]  read_table;
  logic [7:0]  read_bin_a;
  logic [5:0]  read_bin_b;
  logic        done;
  logic [1:0]  status;
  logic [1:0]  slab;
  logic [7:0]  bin_z_out;
  logic [5:0]  bin_x_out;
  logic [5:0]  bin_y_out;
  logic [31:0] read_count;

  // Shadow copy of the registers and counters, updated as each item transfers.
  cfg_t         shadow_cfg;
  count_t       z_hist [Z_BINS];
  count_t       slab_hist [4][XY_BINS][XY_BINS];
  hist_result_t pending_results [$];
  int           mismatches  = 0;
  int           idle_cycles = 0;
  int           burst_left  = 0;
  logic [7:0]   last_zbin;
  logic [1:0]   last_slab;
  logic [5:0]   last_xbin;
  logic [5:0]   last_ybin;

  particle_density_histogrammer_unit u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .opcode(opcode),
    .particle_index(particle_index),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .read_table(read_table),
    .read_bin_a(read_bin_a),
    .read_bin_b(read_bin_b),
    .done(done),
    .status(status),
    .slab(slab),
    .bin_z_out(bin_z_out),
    .bin_x_out(bin_x_out),
    .bin_y_out(bin_y_out),
    .read_count(read_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] q16(int n);
    return 32'(n * 65536);
  endfunction

  // Floor of the Q32.32 product, so negative positions round toward minus infinity.
  function automatic longint scaled_bin(logic [31:0] pos, logic [31:0] inv);
    longint prod;
    prod = longint'($signed(pos)) * longint'({32'd0, inv});
    return prod >>> 32;
  endfunction

  function automatic logic [1:0] pick_slab(logic [31:0] z);
    longint zv;
    longint lo;
    longint up;
    zv = longint'($signed(z));
    lo = longint'($signed(shadow_cfg.lower_wall));
    up = lo + longint'({33'd0, shadow_cfg.wall_gap});
    if (zv > lo - Q_ONE && zv < up + Q_ONE) return SLAB_INNER;
    if ((zv > lo - 3 * Q_ONE && zv < lo - Q_ONE) || (zv > up + Q_ONE && zv < up + 3 * Q_ONE))
      return SLAB_NEAR;
    if ((zv > lo - 5 * Q_ONE && zv < lo - 3 * Q_ONE) ||
        (zv > up + 3 * Q_ONE && zv < up + 5 * Q_ONE))
      return SLAB_MID;
    return SLAB_OUTER;
  endfunction

  function automatic count_t bumped(count_t c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic void clear_histograms();
    foreach (z_hist[i]) z_hist[i] = '0;
    foreach (slab_hist[s, x, y]) slab_hist[s][x][y] = '0;
    shadow_cfg = '{inv_width_z: 32'd65536, inv_width_xy: 32'd65536, lower_wall: '0,
                   wall_gap: '0, first_counted: '0, mobile_count: 16'hFFFF,
                   enable_z: 1'b0, enable_xy: 1'b0};
    last_zbin = '0;
    last_slab = '0;
    last_xbin = '0;
    last_ybin = '0;
  endfunction

  // Updates the shadow counters for one transferred item and returns its result.
  function automatic hist_result_t predict_histogram(hist_item_t it);
    hist_result_t r;
    longint kz;
    longint kx;
    longint ky;
    logic x_ok;
    logic y_ok;
    r = '{status: ST_COUNTED, slab: '0, bin_z: '0, bin_x: '0, bin_y: '0, count: '0};
    if (it.opcode == OP_READ) begin
      r.status = ST_READ;
      if (it.read_table == TBL_Z) begin
        r.count = z_hist[it.read_bin_a];
      end else if (it.read_table <= TBL_SLAB_LAST && it.read_bin_a < XY_BINS) begin
        r.count = slab_hist[it.read_table - 1][it.read_bin_a][it.read_bin_b];
      end else begin
        r.status = ST_RANGE;
      end
    end else if (it.particle_index < shadow_cfg.first_counted ||
                 it.particle_index >= shadow_cfg.mobile_count) begin
      r.status = ST_SKIPPED;
    end else begin
      if (shadow_cfg.enable_z) begin
        kz = scaled_bin(it.pos_z, shadow_cfg.inv_width_z);
        if (kz >= 0 && kz < Z_BINS) begin
          z_hist[kz] = bumped(z_hist[kz]);
          r.bin_z = kz[7:0];
          last_zbin = kz[7:0];
        end else begin
          r.status = ST_RANGE;
        end
      end
      if (shadow_cfg.enable_xy) begin
        kx = scaled_bin(it.pos_x, shadow_cfg.inv_width_xy);
        ky = scaled_bin(it.pos_y, shadow_cfg.inv_width_xy);
        r.slab = pick_slab(it.pos_z);
        x_ok = kx >= 0 && kx < XY_BINS;
        y_ok = ky >= 0 && ky < XY_BINS;
        if (x_ok) r.bin_x = kx[5:0];
        if (y_ok) r.bin_y = ky[5:0];
        if (x_ok && y_ok) begin
          slab_hist[r.slab][kx][ky] = bumped(slab_hist[r.slab][kx][ky]);
          last_slab = r.slab;
          last_xbin = kx[5:0];
          last_ybin = ky[5:0];
        end else begin
          r.status = ST_RANGE;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Results cannot be held off, so every strobe is checked in the cycle it appears.
  always @(posedge clk) begin
    hist_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transfer waiting, status", status, '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (slab !== want.slab) report_mismatch("slab", slab, want.slab);
        if (bin_z_out !== want.bin_z) report_mismatch("bin_z_out", bin_z_out, want.bin_z);
        if (bin_x_out !== want.bin_x) report_mismatch("bin_x_out", bin_x_out, want.bin_x);
        if (bin_y_out !== want.bin_y) report_mismatch("bin_y_out", bin_y_out, want.bin_y);
        if (read_count !== want.count) report_mismatch("read_count", read_count, want.count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("particle_density_histogrammer_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(hist_item_t it);
    @(negedge clk);
    opcode         <= it.opcode;
    particle_index <= it.particle_index;
    pos_x          <= it.pos_x;
    pos_y          <= it.pos_y;
    pos_z          <= it.pos_z;
    read_table     <= it.read_table;
    read_bin_a     <= it.read_bin_a;
    read_bin_b     <= it.read_bin_b;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_histogram(it));
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Bursts of back-to-back transfers with random gaps, so gaps land on every busy phase.
  task automatic paced_send(hist_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 9));
    end
    burst_left--;
    send_item(it);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_INV_Z:     shadow_cfg.inv_width_z   = value;
      REG_INV_XY:    shadow_cfg.inv_width_xy  = value;
      REG_LOWER:     shadow_cfg.lower_wall    = value;
      REG_GAP:       shadow_cfg.wall_gap      = value[30:0];
      REG_FIRST:     shadow_cfg.first_counted = value[15:0];
      REG_MOBILE:    shadow_cfg.mobile_count  = value[15:0];
      REG_ENABLE_Z:  shadow_cfg.enable_z      = value[0];
      REG_ENABLE_XY: shadow_cfg.enable_xy     = value[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(cfg_t c);
    wait_for_drain();
    write_reg(REG_INV_Z, c.inv_width_z);
    write_reg(REG_INV_XY, c.inv_width_xy);
    write_reg(REG_LOWER, c.lower_wall);
    write_reg(REG_GAP, {1'b0, c.wall_gap});
    write_reg(REG_FIRST, {16'd0, c.first_counted});
    write_reg(REG_MOBILE, {16'd0, c.mobile_count});
    write_reg(REG_ENABLE_Z, {31'd0, c.enable_z});
    write_reg(REG_ENABLE_XY, {31'd0, c.enable_xy});
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic hist_item_t make_sample(logic [15:0] idx, logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
    hist_item_t it;
    it = '{opcode: OP_SAMPLE, particle_index: idx, pos_x: x, pos_y: y, pos_z: z,
           read_table: 3'($urandom), read_bin_a: 8'($urandom), read_bin_b: 6'($urandom)};
    return it;
  endfunction

  function automatic hist_item_t make_read(logic [2:0] tbl, logic [7:0] a, logic [5:0] b);
    hist_item_t it;
    it = '{opcode: OP_READ, particle_index: 16'($urandom), pos_x: $urandom, pos_y: $urandom,
           pos_z: $urandom, read_table: tbl, read_bin_a: a, read_bin_b: b};
    return it;
  endfunction

  // A position whose bin mostly lands in range, with some just below zero or past the top.
  function automatic logic [31:0] pos_near_bins(logic [31:0] inv, int nbins);
    longint span;
    longint lo_v;
    longint v;
    if (inv == 0) span = 64'sh7FFF_FFFF;
    else span = ((longint'(nbins) + 4) << 32) / longint'({32'd0, inv});
    if (span > 64'sh7FFF_FFFF) span = 64'sh7FFF_FFFF;
    lo_v = -(span / 16) - 1;
    v = lo_v + longint'({32'd0, $urandom}) % (span - lo_v + 1);
    return v[31:0];
  endfunction

  // A z around the walls, often exactly on a band edge or one step off it.
  function automatic logic [31:0] z_near_walls();
    longint lo;
    longint up;
    longint wall;
    longint v;
    lo = longint'($signed(shadow_cfg.lower_wall));
    up = lo + longint'({33'd0, shadow_cfg.wall_gap});
    wall = $urandom_range(0, 1) ? up : lo;
    case ($urandom_range(0, 2))
      0: v = wall + Q_ONE * (longint'($urandom_range(0, 12)) - 6);
      1: v = wall + Q_ONE * (longint'($urandom_range(0, 6)) * 2 - 5)
             + (longint'($urandom_range(0, 2)) - 1);
      default: v = lo - 6 * Q_ONE +
                   longint'({32'd0, $urandom}) % (up - lo + 12 * Q_ONE + 1);
    endcase
    if (v > 64'sh7FFF_FFFF || v < -64'sh8000_0000) v = longint'($signed($urandom));
    return v[31:0];
  endfunction

  function automatic hist_item_t random_item();
    hist_item_t it;
    int pick;
    it = make_sample(16'($urandom), $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      if ($urandom_range(0, 9) < 6) begin
        // Read back a counter that was just bumped so the counts are non-zero.
        if ($urandom_range(0, 1)) it = make_read(TBL_Z, last_zbin, 6'($urandom));
        else it = make_read(3'(last_slab + 1), {2'b00, last_xbin}, last_ybin);
      end else if ($urandom_range(0, 9) < 8) begin
        it = make_read(3'($urandom_range(0, 4)), 8'($urandom_range(0, XY_BINS - 1)),
                       6'($urandom));
      end else begin
        it = make_read(3'($urandom), 8'($urandom), 6'($urandom));
      end
    end else if (pick < 88) begin
      if (shadow_cfg.mobile_count > shadow_cfg.first_counted)
        it.particle_index = 16'($urandom_range(shadow_cfg.first_counted,
                                               shadow_cfg.mobile_count - 1));
      it.pos_x = pos_near_bins(shadow_cfg.inv_width_xy, XY_BINS);
      it.pos_y = pos_near_bins(shadow_cfg.inv_width_xy, XY_BINS);
      it.pos_z = $urandom_range(0, 1) ? pos_near_bins(shadow_cfg.inv_width_z, Z_BINS)
                                      : z_near_walls();
    end
    return it;
  endfunction

  function automatic cfg_t phase_settings(int p);
    cfg_t c;
    case (p)
      0: c = '{inv_width_z: 32'd65536, inv_width_xy: 32'd65536, lower_wall: '0,
               wall_gap: 31'(q16(10)), first_counted: '0, mobile_count: 16'hFFFF,
               enable_z: 1'b1, enable_xy: 1'b1};
      1: c = '{inv_width_z: 32'h0002_0000, inv_width_xy: 32'h0000_8000,
               lower_wall: q16(-20), wall_gap: '0, first_counted: 16'd100,
               mobile_count: 16'd200, enable_z: 1'b1, enable_xy: 1'b0};
      2: c = '{inv_width_z: '0, inv_width_xy: 32'hFFFF_FFFF, lower_wall: 32'h8000_0000,
               wall_gap: 31'h7FFF_FFFF, first_counted: '0, mobile_count: 16'hFFFF,
               enable_z: 1'b1, enable_xy: 1'b1};
      3: c = '{inv_width_z: 32'hFFFF_FFFF, inv_width_xy: 32'd65536, lower_wall: 32'h7FFF_FFFF,
               wall_gap: '0, first_counted: 16'hFFFE, mobile_count: 16'hFFFF,
               enable_z: 1'b0, enable_xy: 1'b1};
      4: c = '{inv_width_z: 32'd65536, inv_width_xy: 32'd65536, lower_wall: q16(3),
               wall_gap: 31'(q16(4)), first_counted: 16'd5, mobile_count: '0,
               enable_z: 1'b0, enable_xy: 1'b0};
      default: begin
        c.inv_width_z   = $urandom_range(16384, 1 << 19);
        c.inv_width_xy  = $urandom_range(16384, 1 << 19);
        c.lower_wall    = 32'($urandom_range(0, 200 * 65536)) - q16(100);
        c.wall_gap      = 31'($urandom_range(0, 50 * 65536));
        c.first_counted = 16'($urandom_range(0, 500));
        c.mobile_count  = c.first_counted + 16'($urandom_range(1, 2000));
        c.enable_z      = $urandom_range(0, 3) != 0;
        c.enable_xy     = $urandom_range(0, 3) != 0;
      end
    endcase
    // Phase four checks that no index is counted when the mobile count is zero.
    if (p == 4) begin
      c.enable_z  = 1'b1;
      c.enable_xy = 1'b1;
    end
    return c;
  endfunction

  // Register defaults straight after reset: both histograms off, index limits wide open.
  task automatic test_reset_defaults();
    paced_send(make_sample(16'd0, q16(1), q16(2), q16(3)));
    paced_send(make_sample(16'hFFFF, q16(1), q16(2), q16(3)));
    paced_send(make_read(TBL_Z, 8'd255, 6'd0));
    paced_send(make_read(TBL_SLAB_LAST, 8'd63, 6'd63));
  endtask

  // Index limits, bin range edges, slab band edges but the upper wall plus three, and reads.
  task automatic test_bin_and_slab_edges();
    load_settings(phase_settings(0));
    paced_send(make_sample(16'd0, '0, '0, '0));
    load_settings('{inv_width_z: 32'd65536, inv_width_xy: 32'd65536, lower_wall: '0,
                    wall_gap: 31'(q16(10)), first_counted: 16'd10, mobile_count: 16'd1000,
                    enable_z: 1'b1, enable_xy: 1'b1});
    paced_send(make_sample(16'd9, '0, '0, '0));
    paced_send(make_sample(16'd1000, '0, '0, '0));
    paced_send(make_sample(16'd10, '0, '0, '0));
    paced_send(make_sample(16'd999, q16(64) - 1, q16(64) - 1, q16(256) - 1));
    paced_send(make_sample(16'd500, 32'hFFFF_FFFF, q16(5), q16(5)));
    paced_send(make_sample(16'd500, q16(64), q16(5), q16(5)));
    paced_send(make_sample(16'd500, q16(5), q16(5), 32'hFFFF_FFFF));
    paced_send(make_sample(16'd500, q16(5), q16(5), q16(256)));
    paced_send(make_sample(16'd500, q16(1), q16(1), q16(-1)));
    paced_send(make_sample(16'd500, q16(1), q16(1), q16(-2)));
    paced_send(make_sample(16'd500, q16(1), q16(1), q16(-3)));
    paced_send(make_sample(16'd500, q16(1), q16(1), q16(-4)));
    paced_send(make_sample(16'd500, q16(1), q16(1), q16(-5)));
    paced_send(make_sample(16'd500, q16(2), q16(2), q16(11)));
    paced_send(make_sample(16'd500, q16(2), q16(2), q16(12)));
    paced_send(make_sample(16'd500, q16(2), q16(2), q16(14)));
    paced_send(make_sample(16'd500, q16(2), q16(2), q16(15)));
    paced_send(make_sample(16'd500, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    paced_send(make_sample(16'd10, '0, '0, '0));
    paced_send(make_read(TBL_Z, 8'd0, 6'd0));
    paced_send(make_read(3'd1, 8'd0, 6'd0));
    paced_send(make_read(TBL_SLAB_LAST, 8'd63, 6'd63));
    paced_send(make_read(3'd5, 8'd0, 6'd0));
    paced_send(make_read(3'd1, 8'd200, 6'd0));
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      load_settings(phase_settings(p));
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) paced_send(random_item());
    end
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    opcode         = OP_SAMPLE;
    particle_index = '0;
    pos_x          = '0;
    pos_y          = '0;
    pos_z          = '0;
    read_table     = '0;
    read_bin_a     = '0;
    read_bin_b     = '0;
    clear_histograms();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_bin_and_slab_edges();
    test_random_phases();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("particle_density_histogrammer_unit: match");
    end else begin
      $display("particle_density_histogrammer_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pdh_pkg.sv
rtl/pdh_ctrl.sv
rtl/pdh_dp.sv
rtl/particle_density_histogrammer_unit.sv
sim/tb_particle_density_histogrammer_unit.sv
